// ===== sv/mxh_pkg.sv =====
package mxh_pkg;

    localparam int WORD_W      = 64;
    localparam int HALF_W      = WORD_W / 2;
    localparam int PROD_W      = 2 * WORD_W;
    localparam int CNT_W       = 5;
    localparam int BLOCK_BYTES = 16;
    localparam int WORD_BYTES  = WORD_W / 8;
    localparam int ROT_AMOUNT  = 29;

    localparam logic [WORD_W-1:0] HASH_K0 = 64'hc3a5c85c97cb3127;
    localparam logic [WORD_W-1:0] HASH_K1 = 64'hb492b66fbe98f273;

endpackage

// ===== sv/mxh_mul.sv =====
// Iterative 64x64 -> 128 unsigned multiplier built on one 32x32 multiplier.
// Four partial products, one per cycle, each registered before it is
// accumulated. The result is valid in the cycle o_done is high and holds
// until the next start.
module mxh_mul
    import mxh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_a,
    input  logic [WORD_W-1:0] i_b,
    output logic              o_done,
    output logic [PROD_W-1:0] o_product
);

    logic              r_busy;
    logic [2:0]        r_cnt;
    logic              r_done;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_acc;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [PROD_W-1:0] addend;

    // Partial product order: a0*b0, a0*b1, a1*b0, a1*b1
    always_comb begin
        mul_a = r_cnt[1] ? r_a[WORD_W-1:HALF_W] : r_a[HALF_W-1:0];
        mul_b = r_cnt[0] ? r_b[WORD_W-1:HALF_W] : r_b[HALF_W-1:0];
    end

    // Weight of the product registered one step earlier
    always_comb begin
        case (r_cnt)
            3'd1:       addend = {{WORD_W{1'b0}}, r_prod};
            3'd2, 3'd3: addend = {{WORD_W{1'b0}}, r_prod} << HALF_W;
            3'd4:       addend = {r_prod, {WORD_W{1'b0}}};
            default:    addend = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            // flag the product in the cycle after the last accumulate
            r_done <= r_busy && (r_cnt == 3'd4);
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_a    <= i_a;
                r_b    <= i_b;
                r_acc  <= '0;
            end else if (r_busy) begin
                if (r_cnt != 3'd4) begin
                    r_prod <= WORD_W'(mul_a) * WORD_W'(mul_b);
                end
                r_acc <= r_acc + addend;
                if (r_cnt == 3'd4) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt + 3'd1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_acc;

endmodule

// ===== sv/multiply_xor_hash128_top.sv =====
// Streaming 128-bit multiply-xor hash. Feed the message as 16-byte
// little-endian blocks on the slave stream, one block per transaction, with
// tlast on the final transaction of the message; tdata[132:128] carries the
// count of valid bytes (values above 16 act as 16, 0 means no block, which is
// how an empty message or a message of whole blocks is closed). Each block
// costs one 64x64 multiply on a shared iterative unit (four 32x32 partial
// products plus accumulate); tready stays low after a block transaction
// until that multiply is done, so a block is not taken before the last is
// through. The final transaction runs 5 further multiplies (seed fold, two
// mixes, two finishing rotate-multiplies); tready stays low until they are
// done and the digest is loaded into the output register (longer while the
// previous digest still waits there). One 128-bit digest is produced per
// message; the next message can start while that digest waits on the master
// stream. The seed is written through i_cfg_we/i_cfg_wdata and survives
// messages; the user must write it only while the block is idle (not enforced).
module multiply_xor_hash128_top
    import mxh_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration: seed
    input  logic          i_cfg_we,
    input  logic [63:0]   i_cfg_wdata,
    // slave stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // [63:0] block_low, [127:64] block_high, [132:128] valid_bytes, [135:133] zero
    input  logic [135:0]  i_s_tdata,
    input  logic          i_s_tlast,    // last_block
    // master stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // [63:0] digest_low, [127:64] digest_high
    output logic [127:0]  o_m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_BLOCK,
        S_SEED,
        S_MIX1,
        S_MIX2,
        S_FINL,
        S_FINH,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_chain_low;
    logic [WORD_W-1:0] r_chain_high;
    logic [WORD_W-1:0] r_total;
    logic              r_last;
    logic [WORD_W-1:0] r_dig_low;
    logic [WORD_W-1:0] r_dig_high;
    logic              r_out_vld;
    logic [WORD_W-1:0] r_out_low;
    logic [WORD_W-1:0] r_out_high;

    logic [WORD_W-1:0] in_low;
    logic [WORD_W-1:0] in_high;
    logic [CNT_W-1:0]  in_count;
    logic [CNT_W-1:0]  count;
    logic [WORD_W-1:0] blk_low;
    logic [WORD_W-1:0] blk_high;
    logic              s_accept;

    logic              mul_start;
    logic [WORD_W-1:0] mul_a;
    logic [WORD_W-1:0] mul_b;
    logic              mul_done;
    logic [PROD_W-1:0] mul_prod;
    logic [WORD_W-1:0] prod_low;
    logic [WORD_W-1:0] prod_high;

    assign in_low   = i_s_tdata[WORD_W-1:0];
    assign in_high  = i_s_tdata[2*WORD_W-1:WORD_W];
    assign in_count = i_s_tdata[2*WORD_W+CNT_W-1:2*WORD_W];

    assign o_s_tready = (r_state == S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;

    assign prod_low  = mul_prod[WORD_W-1:0];
    assign prod_high = mul_prod[PROD_W-1:WORD_W];

    function automatic logic [WORD_W-1:0] rotl_word(input logic [WORD_W-1:0] h);
        rotl_word = {h[WORD_W-ROT_AMOUNT-1:0], h[WORD_W-1:WORD_W-ROT_AMOUNT]};
    endfunction

    // Clamp the byte count, then zero every byte at or past it
    always_comb begin
        count = (in_count > CNT_W'(BLOCK_BYTES)) ? CNT_W'(BLOCK_BYTES) : in_count;
        for (int i = 0; i < WORD_BYTES; i++) begin
            blk_low[8*i +: 8]  = (count > CNT_W'(i)) ? in_low[8*i +: 8] : 8'h00;
            blk_high[8*i +: 8] = (count > CNT_W'(WORD_BYTES + i)) ?
                                 in_high[8*i +: 8] : 8'h00;
        end
    end

    // Operand select for the shared multiplier; a start goes out in the cycle
    // the previous step finishes, so each finishing step starts once the one before it is done.
    always_comb begin
        mul_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    mul_start = (count != '0) || i_s_tlast;
                    if (count != '0) begin
                        mul_a = r_chain_low ^ blk_low ^ HASH_K0;
                        mul_b = r_chain_high ^ blk_high ^ HASH_K1;
                    end else begin
                        // empty item: go straight to the seed fold
                        mul_a = r_chain_low ^ r_seed ^ HASH_K0;
                        mul_b = r_chain_high ^ r_total ^ HASH_K1;
                    end
                end
            end
            S_BLOCK: begin
                mul_start = mul_done && r_last;
                mul_a     = prod_low ^ r_seed ^ HASH_K0;
                mul_b     = prod_high ^ r_total ^ HASH_K1;
            end
            S_SEED, S_MIX1: begin
                mul_start = mul_done;
                mul_a     = prod_low ^ HASH_K0;
                mul_b     = prod_high ^ HASH_K1;
            end
            S_MIX2: begin
                mul_start = mul_done;
                mul_a     = rotl_word(prod_low);
                mul_b     = HASH_K1;
            end
            S_FINL: begin
                mul_start = mul_done;
                mul_a     = rotl_word(r_chain_high);
                mul_b     = HASH_K1;
            end
            S_FINH, S_EMIT: begin
                mul_start = 1'b0;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    mxh_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_b       (mul_b),
        .o_done    (mul_done),
        .o_product (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seed       <= '0;
            r_chain_low  <= '0;
            r_chain_high <= '0;
            r_total      <= '0;
            r_last       <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end

            // drain the output register unless a new digest loads it this cycle
            if (r_out_vld && i_m_tready && (r_state != S_EMIT)) begin
                r_out_vld <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_last <= i_s_tlast;
                        if (count != '0) begin
                            r_total <= r_total + WORD_W'(count);
                            r_state <= S_BLOCK;
                        end else if (i_s_tlast) begin
                            r_state <= S_SEED;
                        end
                    end
                end
                S_BLOCK: begin
                    if (mul_done) begin
                        r_chain_low  <= prod_low;
                        r_chain_high <= prod_high;
                        r_state      <= r_last ? S_SEED : S_IDLE;
                    end
                end
                S_SEED: begin
                    if (mul_done) begin
                        r_state <= S_MIX1;
                    end
                end
                S_MIX1: begin
                    if (mul_done) begin
                        r_state <= S_MIX2;
                    end
                end
                S_MIX2: begin
                    if (mul_done) begin
                        // hold the high word for the second finishing multiply
                        r_chain_high <= prod_high;
                        r_state      <= S_FINL;
                    end
                end
                S_FINL: begin
                    if (mul_done) begin
                        r_dig_low <= prod_low;
                        r_state   <= S_FINH;
                    end
                end
                S_FINH: begin
                    if (mul_done) begin
                        r_dig_high   <= prod_low;
                        r_chain_low  <= '0;
                        r_chain_high <= '0;
                        r_total      <= '0;
                        r_state      <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    // wait for room in the output register
                    if (!r_out_vld || i_m_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_low  <= r_dig_low;
                        r_out_high <= r_dig_high;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_high, r_out_low};

endmodule
